// ----- rtl/core/gsig_pkg.sv -----
package gsig_pkg;

   // Default values for the top-level parameters.
   localparam int DEF_MAX_SIDE   = 128;
   localparam int DEF_INDEX_BITS = 16;

   // Widths fixed by the register map and the stream payload.
   localparam int CFG_WIDTH    = 8;
   localparam int CFG_IDX_BITS = 2;
   localparam int VERTEX_BITS  = 16;

   // Register indexes of the configuration port.
   localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT    = 2'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_COUNT = 2'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_SKIRT_ENABLE = 2'd2;

   // Side length used after reset.
   localparam logic [CFG_WIDTH-1:0] RESET_SIDE = 8'd2;

   // Sections of the strip, one-hot.
   typedef enum logic [6:0] {
      PH_GRID    = 7'b0000001,
      PH_RESTART = 7'b0000010,
      PH_BOTTOM  = 7'b0000100,
      PH_RIGHT   = 7'b0001000,
      PH_TOP     = 7'b0010000,
      PH_LEFT    = 7'b0100000,
      PH_CLOSE   = 7'b1000000
   } phase_type;

endpackage

// ----- rtl/core/grid_strip_index_generator.sv -----
// Triangle-strip index generator for a row_count by column_count vertex grid.
// Every request transaction returns one index on the response channel in the
// following cycle, one transaction per cycle unless the response is held: the
// index and the strip state come from counter and adder logic, and a new
// request is accepted in the same cycle in which the held response is taken,
// so back-to-back transactions need no gap.
// Grid vertex (r, c) is numbered r*C + c; rows are joined by degenerate pairs.
// With skirt_enable set, a restart pair and the bottom, right, top and left
// border pairs to the skirt vertices (numbered from R*C) follow, then a
// closing pair. rsp_tlast marks the final index; the sequence then wraps.
// A restart request, and any write to a mapped register, start the strip anew.
// Register writes take effect for the request in the following cycle.
module grid_strip_index_generator #(
   parameter int MAX_SIDE   = gsig_pkg::DEF_MAX_SIDE,
   parameter int INDEX_BITS = gsig_pkg::DEF_INDEX_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [0] restart
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gsig_pkg::VERTEX_BITS-1:0]      rsp_tdata,   // [15:0] vertex_index
   output logic                                  rsp_tlast,   // last_of_mesh
   input  logic                                  csr_we,
   input  logic [gsig_pkg::CFG_IDX_BITS-1:0]     csr_index,
   input  logic [gsig_pkg::CFG_WIDTH-1:0]        csr_wdata
);

   localparam int SIDE_BITS  = $clog2(MAX_SIDE + 1);
   localparam int STRIP_BITS = $clog2(MAX_SIDE);
   localparam int CNT_BITS   = SIDE_BITS + 1;

   // Configuration registers.
   logic [gsig_pkg::CFG_WIDTH-1:0] row_ff, row_in;
   logic [gsig_pkg::CFG_WIDTH-1:0] col_ff, col_in;
   logic                           skirt_ff;
   logic                           cfg_hit;

   // Geometry derived from the configuration.
   logic [SIDE_BITS-1:0]  geo_r, geo_c;
   logic [CNT_BITS-1:0]   geo_inner;
   logic                  geo_rows_two;
   logic [INDEX_BITS-1:0] geo_n;
   logic [INDEX_BITS-1:0] geo_right_skirt, geo_right_grid;
   logic [INDEX_BITS-1:0] geo_top_skirt, geo_top_grid;
   logic [INDEX_BITS-1:0] geo_left_skirt, geo_left_grid;

   // Strip state.
   gsig_pkg::phase_type   phase_ff, cur_phase, phase_nx;
   logic [STRIP_BITS-1:0] strip_ff, cur_strip, strip_nx;
   logic [SIDE_BITS-1:0]  col_cnt_ff, cur_col, col_nx;
   logic [INDEX_BITS-1:0] grid_ff, cur_grid, grid_nx;
   logic [INDEX_BITS-1:0] skirt_v_ff, cur_skirt, skirt_nx;
   logic                  half_ff, cur_half, half_nx;
   logic [INDEX_BITS-1:0] prev_ff;

   // Working values.
   logic                  accept;
   logic [INDEX_BITS-1:0] idx_c;
   logic                  last_c;
   logic [CNT_BITS-1:0]   col_p1, c_x, r_x, strip_p2;
   logic                  do_enter;
   logic                  seq_begin;
   gsig_pkg::phase_type   enter_p, enter_tgt;

   // Response register.
   logic                             rsp_valid_ff;
   logic [gsig_pkg::VERTEX_BITS-1:0] rsp_data_ff;
   logic                             rsp_last_ff;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Configuration writes; the next values also feed the geometry unit.
   assign cfg_hit = csr_we && (csr_index inside {gsig_pkg::REG_ROW_COUNT,
                                                 gsig_pkg::REG_COLUMN_COUNT,
                                                 gsig_pkg::REG_SKIRT_ENABLE});

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (reset) begin
         row_in = gsig_pkg::RESET_SIDE;
         col_in = gsig_pkg::RESET_SIDE;
      end else if (csr_we && csr_index == gsig_pkg::REG_ROW_COUNT) begin
         row_in = csr_wdata;
      end else if (csr_we && csr_index == gsig_pkg::REG_COLUMN_COUNT) begin
         col_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skirt_ff <= 1'b0;
      end else if (csr_we && csr_index == gsig_pkg::REG_SKIRT_ENABLE) begin
         skirt_ff <= csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
   end

   gsig_geometry #(
      .MAX_SIDE   (MAX_SIDE),
      .INDEX_BITS (INDEX_BITS)
   ) u_geometry (
      .clock          (clock),
      .row_in         (row_in),
      .col_in         (col_in),
      .rows_ff        (geo_r),
      .cols_ff        (geo_c),
      .inner_rows_ff  (geo_inner),
      .rows_two_ff    (geo_rows_two),
      .vertices_ff    (geo_n),
      .right_skirt_ff (geo_right_skirt),
      .right_grid_ff  (geo_right_grid),
      .top_skirt_ff   (geo_top_skirt),
      .top_grid_ff    (geo_top_grid),
      .left_skirt_ff  (geo_left_skirt),
      .left_grid_ff   (geo_left_grid)
   );

   // A restart request begins the strip before its index is produced.
   always_comb begin
      cur_phase = phase_ff;
      cur_strip = strip_ff;
      cur_col   = col_cnt_ff;
      cur_grid  = grid_ff;
      cur_skirt = skirt_v_ff;
      cur_half  = half_ff;
      if (req_tdata[0]) begin
         cur_phase = gsig_pkg::PH_GRID;
         cur_strip = '0;
         cur_col   = '0;
         cur_grid  = '0;
         cur_skirt = '0;
         cur_half  = 1'b0;
      end
   end

   assign col_p1   = CNT_BITS'(cur_col) + CNT_BITS'(1);
   assign c_x      = CNT_BITS'(geo_c);
   assign r_x      = CNT_BITS'(geo_r);
   assign strip_p2 = CNT_BITS'(cur_strip) + CNT_BITS'(2);

   // Index for the current transaction.
   always_comb begin
      idx_c  = cur_half ? cur_grid : cur_skirt;
      last_c = 1'b0;
      case (cur_phase)
         gsig_pkg::PH_GRID: begin
            if (CNT_BITS'(cur_col) < c_x) begin
               idx_c = cur_half ? cur_grid + INDEX_BITS'(geo_c) : cur_grid;
            end else begin
               idx_c = cur_half ? cur_grid : cur_grid + INDEX_BITS'(geo_c) - INDEX_BITS'(1);
            end
            last_c = cur_half && !skirt_ff && (strip_p2 >= r_x) && (col_p1 == c_x);
         end
         gsig_pkg::PH_RESTART: begin
            idx_c = cur_half ? geo_n : prev_ff;
         end
         default: begin
            last_c = cur_half && (cur_phase == gsig_pkg::PH_CLOSE);
         end
      endcase
   end

   // Next strip state: step the pair, then enter a new section if one ends.
   always_comb begin
      phase_nx  = cur_phase;
      strip_nx  = cur_strip;
      col_nx    = cur_col;
      grid_nx   = cur_grid;
      skirt_nx  = cur_skirt;
      half_nx   = cur_half;
      do_enter  = 1'b0;
      enter_p   = gsig_pkg::PH_GRID;
      enter_tgt = gsig_pkg::PH_GRID;
      seq_begin = 1'b0;
      if (last_c) begin
         seq_begin = 1'b1;
      end else if (!cur_half) begin
         half_nx = 1'b1;
      end else begin
         half_nx = 1'b0;
         case (cur_phase)
            gsig_pkg::PH_GRID: begin
               if (col_p1 < c_x) begin
                  col_nx  = col_p1[SIDE_BITS-1:0];
                  grid_nx = cur_grid + INDEX_BITS'(1);
               end else if (col_p1 == c_x) begin
                  grid_nx = cur_grid + INDEX_BITS'(1);
                  if (strip_p2 < r_x) begin
                     col_nx = geo_c;
                  end else begin
                     do_enter = 1'b1;
                     enter_p  = gsig_pkg::PH_RESTART;
                  end
               end else begin
                  strip_nx = cur_strip + STRIP_BITS'(1);
                  col_nx   = '0;
               end
            end
            gsig_pkg::PH_RESTART: begin
               do_enter = 1'b1;
               enter_p  = gsig_pkg::PH_BOTTOM;
            end
            gsig_pkg::PH_BOTTOM: begin
               skirt_nx = cur_skirt + INDEX_BITS'(1);
               grid_nx  = cur_grid + INDEX_BITS'(1);
               col_nx   = col_p1[SIDE_BITS-1:0];
               do_enter = (col_p1 >= c_x);
               enter_p  = gsig_pkg::PH_RIGHT;
            end
            gsig_pkg::PH_RIGHT: begin
               skirt_nx = cur_skirt + INDEX_BITS'(2);
               grid_nx  = cur_grid + INDEX_BITS'(geo_c);
               col_nx   = col_p1[SIDE_BITS-1:0];
               do_enter = (col_p1 >= geo_inner);
               enter_p  = gsig_pkg::PH_TOP;
            end
            gsig_pkg::PH_TOP: begin
               skirt_nx = cur_skirt - INDEX_BITS'(1);
               grid_nx  = cur_grid - INDEX_BITS'(1);
               col_nx   = col_p1[SIDE_BITS-1:0];
               do_enter = (col_p1 >= c_x);
               enter_p  = gsig_pkg::PH_LEFT;
            end
            gsig_pkg::PH_LEFT: begin
               skirt_nx = cur_skirt - INDEX_BITS'(2);
               grid_nx  = cur_grid - INDEX_BITS'(geo_c);
               col_nx   = col_p1[SIDE_BITS-1:0];
               do_enter = (col_p1 >= geo_inner);
               enter_p  = gsig_pkg::PH_CLOSE;
            end
            default: begin
               seq_begin = 1'b1;
            end
         endcase
      end

      // With two rows the side borders are empty and are skipped.
      if (do_enter) begin
         enter_tgt = enter_p;
         if (geo_rows_two && enter_p == gsig_pkg::PH_RIGHT) begin
            enter_tgt = gsig_pkg::PH_TOP;
         end else if (geo_rows_two && enter_p == gsig_pkg::PH_LEFT) begin
            enter_tgt = gsig_pkg::PH_CLOSE;
         end
         case (enter_tgt)
            gsig_pkg::PH_RIGHT: begin
               skirt_nx = geo_right_skirt;
               grid_nx  = geo_right_grid;
            end
            gsig_pkg::PH_TOP: begin
               skirt_nx = geo_top_skirt;
               grid_nx  = geo_top_grid;
            end
            gsig_pkg::PH_LEFT: begin
               skirt_nx = geo_left_skirt;
               grid_nx  = geo_left_grid;
            end
            default: begin
               skirt_nx = geo_n;
               grid_nx  = '0;
            end
         endcase
         phase_nx = enter_tgt;
         col_nx   = '0;
      end

      if (seq_begin) begin
         phase_nx = gsig_pkg::PH_GRID;
         strip_nx = '0;
         col_nx   = '0;
         grid_nx  = '0;
         skirt_nx = '0;
         half_nx  = 1'b0;
      end
   end

   // Strip state registers; a write to a mapped register restarts the strip.
   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         phase_ff   <= gsig_pkg::PH_GRID;
         strip_ff   <= '0;
         col_cnt_ff <= '0;
         grid_ff    <= '0;
         skirt_v_ff <= '0;
         half_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_nx;
         strip_ff   <= strip_nx;
         col_cnt_ff <= col_nx;
         grid_ff    <= grid_nx;
         skirt_v_ff <= skirt_nx;
         half_ff    <= half_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (accept) begin
         prev_ff <= idx_c;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= idx_c[gsig_pkg::VERTEX_BITS-1:0];
         rsp_last_ff <= last_c;
      end
   end

   // A held response blocks new requests.
   a_hold_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while a response is held");

   // After the final index the strip starts over from its first vertex.
   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last_c) |=> (phase_ff == gsig_pkg::PH_GRID && !half_ff && grid_ff == '0))
      else $error("strip did not wrap after its final index");

   // A restart request always yields grid vertex zero.
   a_restart_first: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tdata[0]) |=> (rsp_tvalid && rsp_tdata == '0 && !rsp_tlast))
      else $error("restart did not return the first index");

   // In the grid section the column counter never runs past the column count.
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == gsig_pkg::PH_GRID) |-> (CNT_BITS'(col_cnt_ff) <= CNT_BITS'(geo_c)))
      else $error("column counter out of range");

endmodule

// ----- rtl/core/gsig_geometry.sv -----
// Registers the clamped grid sides and the start points of each skirt border.
// It works from the next register values, so its outputs always match the
// configuration registers of the top level.
module gsig_geometry #(
   parameter int MAX_SIDE   = gsig_pkg::DEF_MAX_SIDE,
   parameter int INDEX_BITS = gsig_pkg::DEF_INDEX_BITS
) (
   input  logic                                  clock,
   input  logic [gsig_pkg::CFG_WIDTH-1:0]        row_in,
   input  logic [gsig_pkg::CFG_WIDTH-1:0]        col_in,
   output logic [$clog2(MAX_SIDE+1)-1:0]         rows_ff,
   output logic [$clog2(MAX_SIDE+1)-1:0]         cols_ff,
   output logic [$clog2(MAX_SIDE+1):0]           inner_rows_ff,
   output logic                                  rows_two_ff,
   output logic [INDEX_BITS-1:0]                 vertices_ff,
   output logic [INDEX_BITS-1:0]                 right_skirt_ff,
   output logic [INDEX_BITS-1:0]                 right_grid_ff,
   output logic [INDEX_BITS-1:0]                 top_skirt_ff,
   output logic [INDEX_BITS-1:0]                 top_grid_ff,
   output logic [INDEX_BITS-1:0]                 left_skirt_ff,
   output logic [INDEX_BITS-1:0]                 left_grid_ff
);

   localparam int SIDE_BITS = $clog2(MAX_SIDE + 1);
   localparam logic [gsig_pkg::CFG_WIDTH-1:0] SIDE_MAX = gsig_pkg::CFG_WIDTH'(MAX_SIDE);

   logic [SIDE_BITS-1:0]   rows_c;
   logic [SIDE_BITS-1:0]   cols_c;
   logic [2*SIDE_BITS-1:0] prod_c;
   logic [INDEX_BITS-1:0]  r_x;
   logic [INDEX_BITS-1:0]  c_x;
   logic [INDEX_BITS-1:0]  n_x;

   // Out-of-range sides are pulled into the legal range.
   always_comb begin
      if (row_in < 8'd2) begin
         rows_c = SIDE_BITS'(2);
      end else if (row_in > SIDE_MAX) begin
         rows_c = SIDE_BITS'(MAX_SIDE);
      end else begin
         rows_c = row_in[SIDE_BITS-1:0];
      end
      if (col_in < 8'd2) begin
         cols_c = SIDE_BITS'(2);
      end else if (col_in > SIDE_MAX) begin
         cols_c = SIDE_BITS'(MAX_SIDE);
      end else begin
         cols_c = col_in[SIDE_BITS-1:0];
      end
   end

   // Grid vertex count and the border start points.
   assign prod_c = (2*SIDE_BITS)'(rows_c) * (2*SIDE_BITS)'(cols_c);
   assign r_x    = INDEX_BITS'(rows_c);
   assign c_x    = INDEX_BITS'(cols_c);
   assign n_x    = INDEX_BITS'(prod_c);

   always_ff @(posedge clock) begin
      rows_ff        <= rows_c;
      cols_ff        <= cols_c;
      inner_rows_ff  <= (SIDE_BITS+1)'(rows_c) - (SIDE_BITS+1)'(2);
      rows_two_ff    <= (rows_c == SIDE_BITS'(2));
      vertices_ff    <= n_x;
      right_skirt_ff <= n_x + c_x + INDEX_BITS'(1);
      right_grid_ff  <= (c_x << 1) - INDEX_BITS'(1);
      top_skirt_ff   <= n_x + (r_x << 1) + (c_x << 1) - INDEX_BITS'(5);
      top_grid_ff    <= n_x - INDEX_BITS'(1);
      left_skirt_ff  <= n_x + (r_x << 1) + c_x - INDEX_BITS'(6);
      left_grid_ff   <= n_x - (c_x << 1);
   end

endmodule

// ----- dv/grid_strip_index_generator_tb.sv -----
`timescale 1ns / 100ps

module grid_strip_index_generator_tb;

   localparam int MAX_SIDE = gsig_pkg::DEF_MAX_SIDE;
   localparam int VBITS    = gsig_pkg::VERTEX_BITS;
   // Index 3 is outside the register map; a write there must change nothing.
   localparam logic [gsig_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;
   localparam int HOLD_CYCLES = 100;
   localparam int TOTAL_ITEMS = 1200;

   typedef struct packed {
      logic [VBITS-1:0] vertex_index;
      logic             last_of_mesh;
   } strip_index_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata = '0;    // [0] restart
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [VBITS-1:0]                  rsp_tdata;         // [15:0] vertex_index
   logic                              rsp_tlast;         // last_of_mesh
   logic                              csr_we = 1'b0;
   logic [gsig_pkg::CFG_IDX_BITS-1:0] csr_index = '0;
   logic [gsig_pkg::CFG_WIDTH-1:0]    csr_wdata = '0;

   grid_strip_index_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stimulus and scoreboard storage.
   bit              pending_restarts[$];
   strip_index_type expected_indices[$];
   int              mismatches = 0;
   int              requests_queued = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_requests = 0;
   logic            req_taken = 1'b0;

   // Mirror of the strip walker: configuration and sequence state.
   logic [7:0]          cfg_rows;
   logic [7:0]          cfg_cols;
   logic                cfg_skirt;
   gsig_pkg::phase_type section;
   logic [6:0]          strip_cnt;
   logic [7:0]          col_cnt;
   logic [VBITS-1:0]    grid_v;
   logic [VBITS-1:0]    skirt_v;
   logic                second_half;
   logic [VBITS-1:0]    prev_index;

   function automatic int unsigned side_len(input logic [7:0] v);
      if (v < 2) return 2;
      if (v > MAX_SIDE) return MAX_SIDE;
      return 32'(v);
   endfunction

   function automatic void strip_restart();
      section = gsig_pkg::PH_GRID;
      strip_cnt = '0;
      col_cnt = '0;
      grid_v = '0;
      skirt_v = '0;
      second_half = 1'b0;
   endfunction

   // Load the start vertices of a border section; a two-row grid has no
   // side borders, so those sections fall through to the next one.
   function automatic void enter_section(input gsig_pkg::phase_type target);
      int unsigned         r, c, n;
      gsig_pkg::phase_type p;
      r = side_len(cfg_rows);
      c = side_len(cfg_cols);
      n = r * c;
      p = target;
      if (r == 2 && p == gsig_pkg::PH_RIGHT) p = gsig_pkg::PH_TOP;
      else if (r == 2 && p == gsig_pkg::PH_LEFT) p = gsig_pkg::PH_CLOSE;
      case (p)
         gsig_pkg::PH_BOTTOM: begin
            skirt_v = VBITS'(n); grid_v = '0;
         end
         gsig_pkg::PH_RIGHT: begin
            skirt_v = VBITS'(n + c + 1); grid_v = VBITS'(2 * c - 1);
         end
         gsig_pkg::PH_TOP: begin
            skirt_v = VBITS'(n + 2 * r + 2 * c - 5); grid_v = VBITS'(n - 1);
         end
         gsig_pkg::PH_LEFT: begin
            skirt_v = VBITS'(n + 2 * r + c - 6); grid_v = VBITS'((r - 2) * c);
         end
         default: begin
            skirt_v = VBITS'(n); grid_v = '0;
         end
      endcase
      section = p;
      col_cnt = '0;
   endfunction

   // Step to the next pair of the strip once both halves were emitted.
   function automatic void advance_pair();
      int unsigned         r, c, span;
      gsig_pkg::phase_type nxt;
      r = side_len(cfg_rows);
      c = side_len(cfg_cols);
      span = 0;
      nxt = gsig_pkg::PH_CLOSE;
      case (section)
         gsig_pkg::PH_GRID: begin
            if (col_cnt + 1 < c) begin
               col_cnt = 8'(col_cnt + 1);
               grid_v = VBITS'(grid_v + 1);
            end else if (col_cnt + 1 == c) begin
               grid_v = VBITS'(grid_v + 1);
               if (strip_cnt + 2 < r) col_cnt = 8'(c);
               else enter_section(gsig_pkg::PH_RESTART);
            end else begin
               strip_cnt = 7'(strip_cnt + 1);
               col_cnt = '0;
            end
            return;
         end
         gsig_pkg::PH_RESTART: begin
            enter_section(gsig_pkg::PH_BOTTOM);
            return;
         end
         gsig_pkg::PH_BOTTOM: begin
            skirt_v = VBITS'(skirt_v + 1); grid_v = VBITS'(grid_v + 1);
            span = c; nxt = gsig_pkg::PH_RIGHT;
         end
         gsig_pkg::PH_RIGHT: begin
            skirt_v = VBITS'(skirt_v + 2); grid_v = VBITS'(grid_v + c);
            span = r - 2; nxt = gsig_pkg::PH_TOP;
         end
         gsig_pkg::PH_TOP: begin
            skirt_v = VBITS'(skirt_v - 1); grid_v = VBITS'(grid_v - 1);
            span = c; nxt = gsig_pkg::PH_LEFT;
         end
         gsig_pkg::PH_LEFT: begin
            skirt_v = VBITS'(skirt_v - 2); grid_v = VBITS'(grid_v - c);
            span = r - 2; nxt = gsig_pkg::PH_CLOSE;
         end
         default: begin
            strip_restart();
            return;
         end
      endcase
      col_cnt = 8'(col_cnt + 1);
      if (col_cnt >= span) enter_section(nxt);
   endfunction

   // Work out the index that one request transaction must return.
   function automatic strip_index_type next_strip_index(input logic restart);
      int unsigned     r, c, n, idx;
      logic            fin;
      strip_index_type res;
      if (restart) strip_restart();
      r = side_len(cfg_rows);
      c = side_len(cfg_cols);
      n = r * c;
      case (section)
         gsig_pkg::PH_GRID: begin
            if (col_cnt < c) idx = second_half ? grid_v + c : 32'(grid_v);
            else idx = second_half ? 32'(grid_v) : grid_v + c - 1;
            fin = second_half && !cfg_skirt && (strip_cnt + 2 >= r) && (col_cnt + 1 == c);
         end
         gsig_pkg::PH_RESTART: begin
            idx = second_half ? n : 32'(prev_index);
            fin = 1'b0;
         end
         default: begin
            idx = second_half ? 32'(grid_v) : 32'(skirt_v);
            fin = second_half && section == gsig_pkg::PH_CLOSE;
         end
      endcase
      prev_index = idx[VBITS-1:0];
      res.vertex_index = idx[VBITS-1:0];
      res.last_of_mesh = fin;
      if (fin) strip_restart();
      else if (!second_half) second_half = 1'b1;
      else begin
         second_half = 1'b0;
         advance_pair();
      end
      return res;
   endfunction

   function automatic void apply_register(input logic [gsig_pkg::CFG_IDX_BITS-1:0] idx,
                                          input logic [gsig_pkg::CFG_WIDTH-1:0] val);
      case (idx)
         gsig_pkg::REG_ROW_COUNT: cfg_rows = val;
         gsig_pkg::REG_COLUMN_COUNT: cfg_cols = val;
         gsig_pkg::REG_SKIRT_ENABLE: cfg_skirt = val[0];
         default: return;
      endcase
      strip_restart();
   endfunction

   // Number of indices in one full strip, skirt included when enabled.
   function automatic int strip_length(input logic [7:0] rv, input logic [7:0] cv,
                                       input logic sk);
      int r, c, len;
      r = int'(side_len(rv));
      c = int'(side_len(cv));
      len = (r - 1) * 2 * c + (r - 2) * 2;
      if (sk) len += 4 + 4 * c + 4 * (r - 2);
      return len;
   endfunction

   // Request driver: offers the queued restart flags, with random gaps.
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_restarts.size() != 0 && send_idle_pct != 0 &&
                      $urandom_range(0, 99) < send_idle_pct) begin
            send_gap <= $urandom_range(0, 5);
            req_tvalid <= 1'b0;
         end else if (pending_restarts.size() != 0) begin
            req_tdata <= {7'b0, pending_restarts.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver: random stall bursts, plus a long hold on request.
   int hold_served = 0;
   int hold_left = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on each request transaction, check each response.
   always @(posedge clock) begin : monitor
      strip_index_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) expected_indices.push_back(next_strip_index(req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_indices.size() == 0) begin
               $error("unexpected response transaction: vertex_index %0d last_of_mesh %0d",
                      rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = expected_indices.pop_front();
               if (rsp_tdata !== want.vertex_index) begin
                  $error("vertex_index mismatch: expected %0d, got %0d",
                         want.vertex_index, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== want.last_of_mesh) begin
                  $error("last_of_mesh mismatch: expected %0d, got %0d",
                         want.last_of_mesh, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic queue_requests(input int count, input int restart_pct);
      for (int i = 0; i < count; i++) pending_restarts.push_back($urandom_range(0, 99) < restart_pct);
      requests_queued += count;
   endtask

   // Wait until the sender is done and every expected index has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_restarts.size() != 0 || req_tvalid || expected_indices.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   // One register write per cycle; end_writes lowers the enable afterwards.
   task automatic write_reg(input logic [gsig_pkg::CFG_IDX_BITS-1:0] idx,
                            input logic [gsig_pkg::CFG_WIDTH-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_register(idx, val);
      @(negedge clock);
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [7:0] rv, input logic [7:0] cv, input logic sk);
      wait_idle();
      write_reg(gsig_pkg::REG_ROW_COUNT, rv);
      write_reg(gsig_pkg::REG_COLUMN_COUNT, cv);
      write_reg(gsig_pkg::REG_SKIRT_ENABLE, {7'($urandom_range(0, 127)), sk});
      end_writes();
   endtask

   initial begin
      logic [7:0] rv, cv;
      logic       sk;
      int         kind, len, rpct, n_req;

      cfg_rows = gsig_pkg::RESET_SIDE;
      cfg_cols = gsig_pkg::RESET_SIDE;
      cfg_skirt = 1'b0;
      prev_index = '0;
      strip_restart();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default 2x2 grid: one wrap, then an unmapped write that must not restart.
      queue_requests(6, 0);
      wait_idle();
      write_reg(REG_UNMAPPED, 8'hFF);
      end_writes();
      queue_requests(3, 0);

      // Skirt on a two-row grid (side borders skipped), restart mid-strip.
      wait_idle();
      write_reg(gsig_pkg::REG_SKIRT_ENABLE, 8'hFF);
      end_writes();
      queue_requests(8, 0);
      pending_restarts.push_back(1'b1);
      queue_requests(7, 0);
      requests_queued += 1;

      // Long receiver hold while the sender keeps offering.
      configure(8'd4, 8'd5, 1'b1);
      hold_requests++;
      queue_requests(strip_length(8'd4, 8'd5, 1'b1) + 4, 0);

      // Side extremes and out-of-range values, full strips where short.
      send_idle_pct = 20;
      recv_idle_pct = 20;
      configure(8'd128, 8'd128, 1'b1);
      queue_requests(70, 2);
      configure(8'd2, 8'd128, 1'b0);
      queue_requests(strip_length(8'd2, 8'd128, 1'b0) + 10, 0);
      configure(8'd128, 8'd2, 1'b1);
      queue_requests(60, 0);
      configure(8'd0, 8'd255, 1'b1);
      queue_requests(40, 0);
      configure(8'd1, 8'd40, 1'b1);
      queue_requests(strip_length(8'd1, 8'd40, 1'b1) + 6, 0);

      // Random phases: mostly small grids run through whole strips.
      while (requests_queued < TOTAL_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            rv = 8'($urandom_range(2, 6));
            cv = 8'($urandom_range(2, 6));
         end else if (kind < 9) begin
            if ($urandom_range(0, 1)) begin
               rv = 8'($urandom_range(7, 128));
               cv = 8'($urandom_range(2, 3));
            end else begin
               rv = 8'($urandom_range(2, 3));
               cv = 8'($urandom_range(7, 128));
            end
         end else begin
            rv = 8'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(129, 255));
            cv = 8'($urandom_range(0, 1) ? $urandom_range(2, 6) : $urandom_range(129, 255));
         end
         sk = 1'($urandom_range(0, 1));
         len = strip_length(rv, cv, sk);
         rpct = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
         configure(rv, cv, sk);
         case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            default: send_idle_pct = 35;
         endcase
         case ($urandom_range(0, 2))
            0: recv_idle_pct = 0;
            1: recv_idle_pct = 10;
            default: recv_idle_pct = 35;
         endcase
         if (len <= 300) n_req = len * $urandom_range(1, 2) + $urandom_range(0, len - 1);
         else n_req = $urandom_range(20, 80);
         if (n_req > TOTAL_ITEMS - requests_queued) n_req = TOTAL_ITEMS - requests_queued;
         queue_requests(n_req, rpct);
      end

      // Closing stretch at full rate on both sides.
      configure(8'd3, 8'd4, 1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_requests(strip_length(8'd3, 8'd4, 1'b1) + 5, 0);
      wait_idle();
      repeat (10) @(negedge clock);

      if (mismatches == 0 && expected_indices.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
